/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the sliding window median and mean unit.
// Defining NO_ASSERTIONS removes every checked property from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SWMM_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

`define SWMM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SWMM_ASSERT_ALWAYS(label, clk, rstn, expr)

`define SWMM_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* hdl/swmm_pkg.sv */
// Package of the sliding window median and mean unit: widths, defaults and
// the link record passed between neighboring sorting cells. No dependencies.
`default_nettype none

package swmm_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WINDOW_DEFAULT = 5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                above;
        logic                del_seen;
    } link_t;

endpackage

`default_nettype wire

/* hdl/swmm_cell.sv */
// One cell of the sorted window: a sample and its age, updated from both neighbors.
// Depends on swmm_pkg.
`default_nettype none

module swmm_cell #(
    parameter int AGE_W    = 3,
    parameter int INIT_AGE = 0,
    parameter int LAST_AGE = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                shift_en,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] new_sample,
    input  swmm_pkg::link_t                     left_link,
    input  logic [AGE_W-1:0]                    left_age,
    input  swmm_pkg::link_t                     right_link,
    input  logic [AGE_W-1:0]                    right_age,
    output swmm_pkg::link_t                     out_link,
    output logic [AGE_W-1:0]                    out_age
);
    import swmm_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic [AGE_W-1:0]           age_reg;
    logic [AGE_W-1:0]           age_next;
    logic                       above;
    logic                       is_oldest;

    assign above     = value_reg > new_sample;
    assign is_oldest = age_reg == AGE_W'(LAST_AGE);

    always_comb begin
        value_next = value_reg;
        age_next   = age_reg + AGE_W'(1);
        if (left_link.del_seen) begin
            if (!right_link.above) begin
                value_next = $signed(right_link.value);
                age_next   = right_age + AGE_W'(1);
            end else if (!above) begin
                value_next = new_sample;
                age_next   = '0;
            end
        end else if (is_oldest) begin
            if (!right_link.above) begin
                value_next = $signed(right_link.value);
                age_next   = right_age + AGE_W'(1);
            end else if (!left_link.above) begin
                value_next = new_sample;
                age_next   = '0;
            end else begin
                value_next = $signed(left_link.value);
                age_next   = left_age + AGE_W'(1);
            end
        end else if (above) begin
            if (!left_link.above) begin
                value_next = new_sample;
                age_next   = '0;
            end else begin
                value_next = $signed(left_link.value);
                age_next   = left_age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            age_reg   <= AGE_W'(INIT_AGE);
        end else if (shift_en) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign out_link.value    = value_reg;
    assign out_link.above    = above;
    assign out_link.del_seen = left_link.del_seen | is_oldest;
    assign out_age           = age_reg;

endmodule

`default_nettype wire

/* hdl/swmm_div.sv */
// Divides the window sum by the window length with a reciprocal multiply.
// One registered product stage; depends on swmm_pkg.
`default_nettype none

module swmm_div #(
    parameter int WINDOW = swmm_pkg::WINDOW_DEFAULT,
    parameter int SUM_W  = 20
) (
    input  logic                                aclk,
    input  logic                                step_en,
    input  logic signed [SUM_W-1:0]             sum_in,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] mean_out
);
    import swmm_pkg::*;

    localparam int LOG_W  = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int MAG_W  = SUM_W - 1;
    localparam int SHIFT  = MAG_W + LOG_W;
    localparam int MULT_W = MAG_W + 1;
    localparam int PROD_W = MAG_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT =
        MULT_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [SUM_W-1:0]    neg_sum;
    logic [MAG_W-1:0]    magnitude;
    logic [PROD_W-1:0]   prod_reg;
    logic                neg_reg;
    logic [SAMPLE_W-1:0] quotient;

    assign neg_sum   = -sum_in;
    assign magnitude = sum_in[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_in[MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (step_en) begin
            prod_reg <= PROD_W'(magnitude) * PROD_W'(MULT);
            neg_reg  <= sum_in[SUM_W-1];
        end
    end

    assign quotient = prod_reg[SHIFT +: SAMPLE_W];
    assign mean_out = neg_reg ? $signed(-quotient) : $signed(quotient);

endmodule

`default_nettype wire

/* hdl/sliding_window_median_mean_unit.sv */
// Sliding window median and mean unit. Each accepted sample enters a window of the
// last WINDOW samples, kept sorted in a row of cells that drop the oldest sample and
// insert the new one in one update, so the unit takes one item per clock cycle while
// m_ready does not hold the output. Median: a stage register, then the output register;
// truncated mean: the running sum, a reciprocal multiply stage, the output register.
// After reset the window holds zeros. Depends on swmm_pkg, swmm_cell, swmm_div.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_median_mean_unit #(
    parameter int WINDOW = swmm_pkg::WINDOW_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] m_median_value,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] m_mean_value
);
    import swmm_pkg::*;

    localparam int LOG_W   = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int AGE_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = SAMPLE_W + LOG_W + 1;
    localparam int MID_IDX = WINDOW / 2;

    logic                       stage_en;
    logic                       accept;
    link_t                      cell_link [WINDOW];
    logic [AGE_W-1:0]           cell_age  [WINDOW];
    logic [WINDOW-1:0]          oldest_vec;
    logic [WINDOW-1:0]          order_vec;
    logic [SAMPLE_W-1:0]        oldest_value;
    logic [SAMPLE_W-1:0]        youngest_value;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       v1_reg;
    logic                       v2_reg;
    logic signed [SAMPLE_W-1:0] med2_reg;
    logic signed [SAMPLE_W-1:0] mean_q;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_median_value_reg;
    logic signed [SAMPLE_W-1:0] m_mean_value_reg;

    assign stage_en = !m_valid_reg || m_ready;
    assign s_ready  = stage_en;
    assign accept   = s_valid && stage_en;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        link_t            left_in;
        link_t            right_in;
        logic [AGE_W-1:0] left_age;
        logic [AGE_W-1:0] right_age;

        if (i == 0) begin : g_first
            assign left_in  = '{value: '0, above: 1'b0, del_seen: 1'b0};
            assign left_age = '0;
        end else begin : g_inner_left
            assign left_in  = cell_link[i-1];
            assign left_age = cell_age[i-1];
        end

        if (i == WINDOW - 1) begin : g_last
            assign right_in  = '{value: '0, above: 1'b1, del_seen: 1'b0};
            assign right_age = '0;
        end else begin : g_inner_right
            assign right_in  = cell_link[i+1];
            assign right_age = cell_age[i+1];
        end

        swmm_cell #(
            .AGE_W    (AGE_W),
            .INIT_AGE (i),
            .LAST_AGE (WINDOW - 1)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (accept),
            .new_sample (s_sample),
            .left_link  (left_in),
            .left_age   (left_age),
            .right_link (right_in),
            .right_age  (right_age),
            .out_link   (cell_link[i]),
            .out_age    (cell_age[i])
        );

        assign oldest_vec[i] = cell_link[i].del_seen & ~left_in.del_seen;
        assign order_vec[i]  = (i == WINDOW - 1) ? 1'b1 :
                               ($signed(cell_link[i].value) <= $signed(right_in.value));
    end

    always_comb begin
        oldest_value   = '0;
        youngest_value = '0;
        for (int i = 0; i < WINDOW; i++) begin
            oldest_value   = oldest_value | (oldest_vec[i] ? cell_link[i].value : '0);
            youngest_value = youngest_value |
                             ((cell_age[i] == '0) ? cell_link[i].value : '0);
        end
    end

    assign sum_next = sum_reg
                    + $signed({{(SUM_W-SAMPLE_W){s_sample[SAMPLE_W-1]}}, s_sample})
                    - $signed({{(SUM_W-SAMPLE_W){oldest_value[SAMPLE_W-1]}}, oldest_value});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (stage_en) begin
            if (s_valid) begin
                sum_reg <= sum_next;
            end
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            med2_reg           <= $signed(cell_link[MID_IDX].value);
            m_median_value_reg <= med2_reg;
            m_mean_value_reg   <= mean_q;
        end
    end

    swmm_div #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .step_en  (stage_en),
        .sum_in   (sum_reg),
        .mean_out (mean_q)
    );

    assign m_valid        = m_valid_reg;
    assign m_median_value = m_median_value_reg;
    assign m_mean_value   = m_mean_value_reg;

    `SWMM_ASSERT_ALWAYS(a_one_oldest, aclk, aresetn, $onehot(oldest_vec))
    `SWMM_ASSERT_ALWAYS(a_sorted, aclk, aresetn, &order_vec)
    `SWMM_ASSERT_NEXT(a_youngest, aclk, aresetn, accept, youngest_value == $past(s_sample))

endmodule

`default_nettype wire

/* tb/sv/sliding_window_median_mean_unit_tb.sv */
// Self-checking testbench for sliding_window_median_mean_unit: a scoreboard class keeps its own
// copy of the sample window and checks the median and mean of every result item.
// Depends on swmm_pkg and the unit's RTL.

module sliding_window_median_mean_unit_tb;

    localparam int WIN          = swmm_pkg::WINDOW_DEFAULT;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CALM_FROM    = 1000;
    localparam int PRESSURE_AT  = 400;
    localparam int PRESSURE_LEN = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 20;

    typedef logic signed [swmm_pkg::SAMPLE_W-1:0] sample_t;

    class median_mean_scoreboard;
        sample_t recent_samples [WIN];
        sample_t expected_median [$];
        sample_t expected_mean [$];
        int      mismatches;

        function new();
            foreach (recent_samples[i]) recent_samples[i] = '0;
            mismatches = 0;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("MISMATCH at %0t: %s", $time, what);
            end
        endfunction

        function int pending();
            return expected_median.size();
        endfunction

        function void note_sample(sample_t sample);
            sample_t ordered [WIN];
            sample_t key;
            int      total;
            int      i;
            int      j;
            for (i = WIN - 1; i > 0; i--) begin
                recent_samples[i] = recent_samples[i - 1];
            end
            recent_samples[0] = sample;
            total = 0;
            for (i = 0; i < WIN; i++) begin
                key = recent_samples[i];
                total += key;
                j = i;
                while (j > 0 && ordered[j - 1] > key) begin
                    ordered[j] = ordered[j - 1];
                    j--;
                end
                ordered[j] = key;
            end
            expected_median.push_back(ordered[WIN / 2]);
            expected_mean.push_back(sample_t'(total / WIN));
        endfunction

        function void check_result(sample_t median, sample_t mean);
            sample_t want_median;
            sample_t want_mean;
            if (expected_median.size() == 0) begin
                flag($sformatf("item with nothing expected: median %0d mean %0d", median, mean));
                return;
            end
            want_median = expected_median.pop_front();
            want_mean   = expected_mean.pop_front();
            if (median !== want_median) begin
                flag($sformatf("median expected %0d, got %0d", want_median, median));
            end
            if (mean !== want_mean) begin
                flag($sformatf("mean expected %0d, got %0d", want_mean, mean));
            end
        endfunction
    endclass

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    sample_t s_sample;
    logic    m_valid;
    logic    m_ready;
    sample_t m_median_value;
    sample_t m_mean_value;

    bit hold_request;
    bit calm;

    median_mean_scoreboard sb;

    sliding_window_median_mean_unit #(
        .WINDOW(WIN)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_median_value(m_median_value),
        .m_mean_value  (m_mean_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_sample(s_sample);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_median_value, m_mean_value);
            end
        end
    end

    task automatic send_sample(input sample_t value);
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    function automatic sample_t pick_sample(sample_t previous);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5:       return sample_t'(int'($urandom_range(0, 16)) - 8);
            6: begin
                case ($urandom_range(0, 3))
                    0:       return sample_t'(32767);
                    1:       return sample_t'(-32768);
                    2:       return sample_t'(-1);
                    default: return sample_t'(0);
                endcase
            end
            7:       return sample_t'(32767 - int'($urandom_range(0, 255)));
            8:       return sample_t'(-32768 + int'($urandom_range(0, 255)));
            default: return previous;
        endcase
    endfunction

    initial begin : result_sink
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    initial begin : sample_source
        sample_t directed_samples [25] = '{
            32767, 32767, 32767, 32767, 32767,
            -32768, -32768, -32768, -32768, -32768,
            0, -1, -1, -1, -1,
            1, -2, 3, -4, 5,
            16'sh5555, 16'shAAAA, 32767, -32768, 0
        };
        sample_t previous;
        int      n;

        sb           = new();
        hold_request = 1'b0;
        calm         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_sample     = '0;
        previous     = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first items see a window still partly filled with the zeros from reset.
        foreach (directed_samples[k]) begin
            send_sample(directed_samples[k]);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PRESSURE_AT) begin
                hold_request = 1'b1;
            end
            if (n >= CALM_FROM) begin
                calm = 1'b1;
            end
            previous = pick_sample(previous);
            send_sample(previous);
            if (!calm && (n < PRESSURE_AT || n >= PRESSURE_AT + PRESSURE_LEN)
                    && $urandom_range(0, 3) == 0) begin
                pause_sender($urandom_range(1, 11));
            end
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sliding_window_median_mean_unit.f */
+incdir+hdl
hdl/swmm_pkg.sv
hdl/swmm_cell.sv
hdl/swmm_div.sv
hdl/sliding_window_median_mean_unit.sv
tb/sv/sliding_window_median_mean_unit_tb.sv
